/* hw/rtl/ospa_pkg.sv */
package ospa_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int COORD_W        = 16;
    localparam int CUT_W          = 16;
    localparam int DIST_W         = 16;
    localparam int COST_W         = 32;
    localparam int SUM_W          = 40;
    localparam int POT_W          = 48;

    localparam logic signed [POT_W-1:0] POT_HUGE = POT_W'(64'h0000_4000_0000_0000);
    localparam logic [CUT_W-1:0] CUTOFF_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_TRUTH = 2'd0,
        KIND_EST   = 2'd1,
        KIND_EVAL  = 2'd2
    } t_kind;

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_C2    = 20'h00002,
        S_PRD   = 20'h00004,
        S_PDX   = 20'h00008,
        S_MX    = 20'h00010,
        S_MY    = 20'h00020,
        S_CWR   = 20'h00040,
        S_HROW  = 20'h00080,
        S_HMARK = 20'h00100,
        S_HSRD  = 20'h00200,
        S_HSSUB = 20'h00400,
        S_HSCMP = 20'h00800,
        S_HUPD  = 20'h01000,
        S_HAUG  = 20'h02000,
        S_HTRD  = 20'h04000,
        S_HTAC  = 20'h08000,
        S_PEN   = 20'h10000,
        S_DIV   = 20'h20000,
        S_SQ    = 20'h40000,
        S_OUT   = 20'h80000
    } t_state;

endpackage

/* hw/rtl/ospa_ram.sv */
module ospa_ram #(
    parameter int W = 32,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [0:D-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* hw/rtl/ospa_distance_optimal_assignment.sv */
// Order-2 OSPA distance between a truth set and an estimate set of 2-D points.
// Input channel (i_valid/o_ready): kind 0 loads a truth point, kind 1 an estimate
// point, kind 2 evaluates and empties both sets; kind 3 is taken and ignored.
// A load transfer leaves the block ready for the next one; a load into a full
// set is dropped and flagged in the next result.
// An evaluate transfer starts a sequencer around one shared squaring multiplier.
// With r rows (smaller set) and c columns it builds the clipped cost table, runs
// the Hungarian search over it, totals the matched costs, adds the squared cutoff
// for each of the c-r unmatched points, divides by c and takes the square root.
// The input is not ready meanwhile. The result waits in an output register
// (o_valid/i_ready); a stall by the receiver holds it, and the block takes new
// loads while it waits. Reset restores a cutoff of 65535, empties both sets and
// drops any pending result. The cutoff is written through i_cfg_we/i_cfg_data;
// the user writes it only while idle, as the block does not enforce this.
module ospa_distance_optimal_assignment #(
    parameter int MAX_POINTS = ospa_pkg::MAX_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_kind,
    input  logic signed [ospa_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [ospa_pkg::COORD_W-1:0] i_point_y,
    input  logic                              i_cfg_we,
    input  logic [ospa_pkg::CUT_W-1:0]        i_cfg_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ospa_pkg::DIST_W-1:0]       o_ospa_distance,
    output logic [$clog2(MAX_POINTS+1)-1:0]   o_matched_pairs,
    output logic                              o_capacity_overflow
);
    import ospa_pkg::*;

    localparam int IW  = $clog2(MAX_POINTS + 1);
    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CD  = 1 << (2 * AW);
    localparam int PW2 = 2 * COORD_W;
    localparam int SQW = 2 * DIST_W;
    localparam int NW  = $clog2(SUM_W);

    t_state                    r_state;
    logic [CUT_W-1:0]          r_cutoff;
    logic [IW-1:0]             r_tcount, r_ecount;
    logic                      r_ovf;
    logic [IW-1:0]             r_nr, r_nc;
    logic                      r_rows_truth;
    logic                      r_ovf_out;
    logic [COST_W-1:0]         r_c2;
    logic [IW-1:0]             r_i, r_j, r_j0, r_j1, r_i0, r_k;
    logic signed [COORD_W:0]   r_dx, r_dy;
    logic [PW2+1:0]            r_dx2, r_prod;
    logic signed [POT_W-1:0]   r_pri0, r_delta, r_cur;
    logic [SUM_W-1:0]          r_sum, r_quo;
    logic [IW-1:0]             r_rem;
    logic [NW-1:0]             r_cnt;
    logic [SQW-1:0]            r_sv, r_res, r_bit;
    logic                      r_out_valid;
    logic [DIST_W-1:0]         r_out_dist;
    logic [IW-1:0]             r_out_pairs;
    logic                      r_out_ovf;

    logic signed [POT_W-1:0]   r_pot_row [0:MAX_POINTS];
    logic signed [POT_W-1:0]   r_pot_col [0:MAX_POINTS];
    logic signed [POT_W-1:0]   r_min_col [0:MAX_POINTS];
    logic [IW-1:0]             r_owner   [0:MAX_POINTS];
    logic [IW-1:0]             r_prev    [0:MAX_POINTS];
    logic                      r_used    [0:MAX_POINTS];
    logic                      r_rflag   [0:MAX_POINTS];

    logic signed [COORD_W:0]   mul_a;
    logic signed [PW2+1:0]     mul_p;
    logic [2*COORD_W-1:0]      tru_rd, est_rd;
    logic [COST_W-1:0]         cost_rd, cost_wd;
    logic [PW2+2:0]            d2;
    logic [IW-1:0]             row_sel, row_m1, col_m1;
    logic                      tru_we, est_we, cost_we;
    logic [AW-1:0]             tru_ra, est_ra;
    logic                      cmp_lt, d_lt;
    logic signed [POT_W-1:0]   m_val;
    logic [IW-1:0]             scan_j1;
    logic [IW:0]               rem_sh;
    logic                      div_ge;
    logic [SUM_W-1:0]          quo_nx;
    logic [SQW:0]              sq_t;
    logic                      in_xfer;

    assign o_ready             = (r_state == S_IDLE);
    assign o_valid             = r_out_valid;
    assign o_ospa_distance     = r_out_dist;
    assign o_matched_pairs     = r_out_pairs;
    assign o_capacity_overflow = r_out_ovf;
    assign in_xfer             = i_valid && o_ready;

    always_comb begin
        case (r_state)
            S_C2:    mul_a = {1'b0, r_cutoff};
            S_MY:    mul_a = r_dy;
            default: mul_a = r_dx;
        endcase
    end
    assign mul_p = mul_a * mul_a;

    assign tru_we = in_xfer && (i_kind == KIND_TRUTH) && (r_tcount < IW'(MAX_POINTS));
    assign est_we = in_xfer && (i_kind == KIND_EST) && (r_ecount < IW'(MAX_POINTS));
    assign tru_ra = r_rows_truth ? r_i[AW-1:0] : r_j[AW-1:0];
    assign est_ra = r_rows_truth ? r_j[AW-1:0] : r_i[AW-1:0];

    assign d2      = {1'b0, r_dx2} + {1'b0, r_prod};
    assign cost_wd = (d2 < (PW2+3)'(r_c2)) ? d2[COST_W-1:0] : r_c2;
    assign cost_we = (r_state == S_CWR);
    assign row_sel = (r_state == S_HTRD) ? r_owner[r_j] : r_i0;
    assign row_m1  = row_sel - IW'(1);
    assign col_m1  = r_j - IW'(1);

    assign cmp_lt  = r_cur < r_min_col[r_j];
    assign m_val   = cmp_lt ? r_cur : r_min_col[r_j];
    assign d_lt    = m_val < r_delta;
    assign scan_j1 = d_lt ? r_j : r_j1;

    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign div_ge = rem_sh >= {1'b0, r_nc};
    assign quo_nx = {r_quo[SUM_W-2:0], div_ge};
    assign sq_t   = {1'b0, r_res} + {1'b0, r_bit};

    ospa_ram #(.W(2*COORD_W), .D(MAX_POINTS)) u_truth_ram (
        .i_clk   (i_clk),
        .i_we    (tru_we),
        .i_waddr (r_tcount[AW-1:0]),
        .i_wdata ({i_point_x, i_point_y}),
        .i_raddr (tru_ra),
        .o_rdata (tru_rd)
    );

    ospa_ram #(.W(2*COORD_W), .D(MAX_POINTS)) u_est_ram (
        .i_clk   (i_clk),
        .i_we    (est_we),
        .i_waddr (r_ecount[AW-1:0]),
        .i_wdata ({i_point_x, i_point_y}),
        .i_raddr (est_ra),
        .o_rdata (est_rd)
    );

    ospa_ram #(.W(COST_W), .D(CD)) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (cost_we),
        .i_waddr ({r_i[AW-1:0], r_j[AW-1:0]}),
        .i_wdata (cost_wd),
        .i_raddr ({row_m1[AW-1:0], col_m1[AW-1:0]}),
        .o_rdata (cost_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cutoff    <= CUTOFF_RESET;
            r_tcount    <= '0;
            r_ecount    <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cutoff <= i_cfg_data;
            end
            if (r_out_valid && i_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        case (i_kind)
                            KIND_TRUTH: begin
                                if (tru_we) begin
                                    r_tcount <= r_tcount + IW'(1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            KIND_EST: begin
                                if (est_we) begin
                                    r_ecount <= r_ecount + IW'(1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            KIND_EVAL: begin
                                r_rows_truth <= (r_tcount <= r_ecount);
                                r_nr      <= (r_tcount <= r_ecount) ? r_tcount : r_ecount;
                                r_nc      <= (r_tcount <= r_ecount) ? r_ecount : r_tcount;
                                r_ovf_out <= r_ovf;
                                r_tcount  <= '0;
                                r_ecount  <= '0;
                                r_ovf     <= 1'b0;
                                r_sum     <= '0;
                                for (int k = 0; k <= MAX_POINTS; k++) begin
                                    r_pot_row[k] <= '0;
                                    r_pot_col[k] <= '0;
                                    r_owner[k]   <= '0;
                                    r_prev[k]    <= '0;
                                end
                                r_state <= S_C2;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_C2: begin
                    r_c2 <= mul_p[COST_W-1:0];
                    r_i  <= '0;
                    r_j  <= '0;
                    if (r_nr == '0) begin
                        r_k     <= r_nc - r_nr;
                        r_state <= S_PEN;
                    end else begin
                        r_state <= S_PRD;
                    end
                end
                S_PRD: begin
                    r_state <= S_PDX;
                end
                S_PDX: begin
                    r_dx <= $signed({tru_rd[2*COORD_W-1], tru_rd[2*COORD_W-1:COORD_W]})
                          - $signed({est_rd[2*COORD_W-1], est_rd[2*COORD_W-1:COORD_W]});
                    r_dy <= $signed({tru_rd[COORD_W-1], tru_rd[COORD_W-1:0]})
                          - $signed({est_rd[COORD_W-1], est_rd[COORD_W-1:0]});
                    r_state <= S_MX;
                end
                S_MX: begin
                    r_dx2   <= mul_p;
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_prod  <= mul_p;
                    r_state <= S_CWR;
                end
                S_CWR: begin
                    if (r_j == r_nc - IW'(1)) begin
                        r_j <= '0;
                        if (r_i == r_nr - IW'(1)) begin
                            r_i     <= IW'(1);
                            r_state <= S_HROW;
                        end else begin
                            r_i     <= r_i + IW'(1);
                            r_state <= S_PRD;
                        end
                    end else begin
                        r_j     <= r_j + IW'(1);
                        r_state <= S_PRD;
                    end
                end
                S_HROW: begin
                    r_owner[0] <= r_i;
                    r_j0       <= '0;
                    for (int k = 0; k <= MAX_POINTS; k++) begin
                        r_min_col[k] <= POT_HUGE;
                        r_used[k]    <= 1'b0;
                        r_rflag[k]   <= 1'b0;
                    end
                    r_state <= S_HMARK;
                end
                S_HMARK: begin
                    r_used[r_j0]           <= 1'b1;
                    r_rflag[r_owner[r_j0]] <= 1'b1;
                    r_i0    <= r_owner[r_j0];
                    r_pri0  <= r_pot_row[r_owner[r_j0]];
                    r_delta <= POT_HUGE;
                    r_j1    <= '0;
                    r_j     <= IW'(1);
                    r_state <= S_HSRD;
                end
                S_HSRD: begin
                    if (!r_used[r_j]) begin
                        r_state <= S_HSSUB;
                    end else if (r_j != r_nc) begin
                        r_j <= r_j + IW'(1);
                    end else if (r_j1 == '0) begin
                        r_state <= S_HAUG;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_HUPD;
                    end
                end
                S_HSSUB: begin
                    r_cur   <= $signed(POT_W'(cost_rd)) - r_pri0 - r_pot_col[r_j];
                    r_state <= S_HSCMP;
                end
                S_HSCMP: begin
                    if (cmp_lt) begin
                        r_min_col[r_j] <= r_cur;
                        r_prev[r_j]    <= r_j0;
                    end
                    if (d_lt) begin
                        r_delta <= m_val;
                    end
                    r_j1 <= scan_j1;
                    if (r_j != r_nc) begin
                        r_j     <= r_j + IW'(1);
                        r_state <= S_HSRD;
                    end else if (scan_j1 == '0) begin
                        r_state <= S_HAUG;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_HUPD;
                    end
                end
                S_HUPD: begin
                    if (r_used[r_k]) begin
                        r_pot_col[r_k] <= r_pot_col[r_k] - r_delta;
                    end else begin
                        r_min_col[r_k] <= r_min_col[r_k] - r_delta;
                    end
                    if (r_rflag[r_k]) begin
                        r_pot_row[r_k] <= r_pot_row[r_k] + r_delta;
                    end
                    if (r_k == r_nc) begin
                        r_j0 <= r_j1;
                        if (r_owner[r_j1] != '0) begin
                            r_state <= S_HMARK;
                        end else begin
                            r_state <= S_HAUG;
                        end
                    end else begin
                        r_k <= r_k + IW'(1);
                    end
                end
                S_HAUG: begin
                    if (r_j0 != '0) begin
                        r_owner[r_j0] <= r_owner[r_prev[r_j0]];
                        r_j0          <= r_prev[r_j0];
                    end else if (r_i == r_nr) begin
                        r_j     <= IW'(1);
                        r_state <= S_HTRD;
                    end else begin
                        r_i     <= r_i + IW'(1);
                        r_state <= S_HROW;
                    end
                end
                S_HTRD: begin
                    if (r_owner[r_j] != '0) begin
                        r_state <= S_HTAC;
                    end else if (r_j != r_nc) begin
                        r_j <= r_j + IW'(1);
                    end else begin
                        r_k     <= r_nc - r_nr;
                        r_state <= S_PEN;
                    end
                end
                S_HTAC: begin
                    r_sum <= r_sum + SUM_W'(cost_rd);
                    if (r_j != r_nc) begin
                        r_j     <= r_j + IW'(1);
                        r_state <= S_HTRD;
                    end else begin
                        r_k     <= r_nc - r_nr;
                        r_state <= S_PEN;
                    end
                end
                S_PEN: begin
                    if (r_k != '0) begin
                        r_sum <= r_sum + SUM_W'(r_c2);
                        r_k   <= r_k - IW'(1);
                    end else if (r_nc == '0) begin
                        r_res   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_quo   <= r_sum;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? IW'(rem_sh - {1'b0, r_nc}) : rem_sh[IW-1:0];
                    r_quo <= quo_nx;
                    if (r_cnt == NW'(SUM_W - 1)) begin
                        r_sv    <= quo_nx[SQW-1:0];
                        r_res   <= '0;
                        r_bit   <= SQW'(1) << (SQW - 2);
                        r_cnt   <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_cnt <= r_cnt + NW'(1);
                    end
                end
                S_SQ: begin
                    if ({1'b0, r_sv} >= sq_t) begin
                        r_sv  <= r_sv - sq_t[SQW-1:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + NW'(1);
                    if (r_cnt == NW'(DIST_W - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_dist  <= r_res[DIST_W-1:0];
                        r_out_pairs <= r_nr;
                        r_out_ovf   <= r_ovf_out;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    ap_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tcount <= IW'(MAX_POINTS)) && (r_ecount <= IW'(MAX_POINTS)))
        else $error("Point count exceeds the set capacity.");

    ap_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_kind == KIND_EVAL) |=> !o_ready)
        else $error("Input ready straight after an evaluate transfer.");

    ap_aug_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HAUG) |-> (r_j0 <= r_nc))
        else $error("Augmenting path left the column range.");

    ap_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_out_valid) |=> (r_out_valid && o_ready))
        else $error("Finished result was not presented.");
`endif

endmodule

/* verif/ospa_distance_optimal_assignment_tb.sv */
module ospa_distance_optimal_assignment_tb;
    import ospa_pkg::*;

    localparam int NPTS = MAX_POINTS_DEF;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] distance;
        logic [4:0]  pairs;
        logic        ovf;
    } ospa_t;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] x;
        logic [15:0] y;
        bit          typed;
        ospa_t       res;
    } row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind = '0;
    logic signed [15:0] i_point_x = '0;
    logic signed [15:0] i_point_y = '0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_ospa_distance;
    logic [4:0]  o_matched_pairs;
    logic        o_capacity_overflow;

    ospa_distance_optimal_assignment uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_point_x(i_point_x), .i_point_y(i_point_y),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_ospa_distance(o_ospa_distance), .o_matched_pairs(o_matched_pairs),
        .o_capacity_overflow(o_capacity_overflow)
    );

    // Predictor state.
    logic [15:0] cut_reg = CUTOFF_RESET;
    logic [31:0] truth_set [NPTS];
    logic [31:0] est_set [NPTS];
    int          n_truth = 0;
    int          n_est = 0;
    bit          dropped = 1'b0;
    longint      cost_tab [NPTS][NPTS];

    ospa_t       pending_ospa [$];
    int          errors = 0;
    int          burst_left = 1;
    int          sent = 0;
    bit          hold_go = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_cnt = 0;
    int          pct_cnt = 0;
    int          ready_pct = 100;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint clipped_sq_dist(logic [31:0] a, logic [31:0] b);
        logic signed [15:0] ax, ay, bx, by;
        longint dx, dy, d2, c2;
        ax = a[31:16]; ay = a[15:0]; bx = b[31:16]; by = b[15:0];
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        d2 = dx * dx + dy * dy;
        c2 = longint'(cut_reg) * longint'(cut_reg);
        return d2 < c2 ? d2 : c2;
    endfunction

    function automatic longint table_cost(int r, int c, bit rows_truth);
        return rows_truth ? cost_tab[r][c] : cost_tab[c][r];
    endfunction

    // Hungarian method, nr rows <= nc columns, 1-based indices.
    function automatic longint min_assign_cost(int nr, int nc, bit rows_truth);
        longint u [NPTS+1];
        longint v [NPTS+1];
        longint mn [NPTS+1];
        int     own [NPTS+1];
        int     way [NPTS+1];
        bit     used [NPTS+1];
        longint delta, cur, total;
        int     i0, j0, j1;
        for (int j = 0; j <= NPTS; j++) begin
            u[j] = 0; v[j] = 0; own[j] = 0; way[j] = 0;
        end
        for (int i = 1; i <= nr; i++) begin
            own[0] = i;
            j0 = 0;
            for (int j = 0; j <= nc; j++) begin
                mn[j] = 64'sh4000_0000_0000_0000;
                used[j] = 1'b0;
            end
            do begin
                used[j0] = 1'b1;
                i0 = own[j0];
                j1 = 0;
                delta = 64'sh4000_0000_0000_0000;
                for (int j = 1; j <= nc; j++) begin
                    if (!used[j]) begin
                        cur = table_cost(i0 - 1, j - 1, rows_truth) - u[i0] - v[j];
                        if (cur < mn[j]) begin
                            mn[j] = cur;
                            way[j] = j0;
                        end
                        if (mn[j] < delta) begin
                            delta = mn[j];
                            j1 = j;
                        end
                    end
                end
                if (j1 == 0) break;
                for (int j = 0; j <= nc; j++) begin
                    if (used[j]) begin
                        u[own[j]] += delta;
                        v[j] -= delta;
                    end else begin
                        mn[j] -= delta;
                    end
                end
                j0 = j1;
            end while (own[j0] != 0);
            while (j0 != 0) begin
                j1 = way[j0];
                own[j0] = own[j1];
                j0 = j1;
            end
        end
        total = 0;
        for (int j = 1; j <= nc; j++)
            if (own[j] != 0) total += table_cost(own[j] - 1, j - 1, rows_truth);
        return total;
    endfunction

    function automatic longint int_sqrt(longint val);
        longint root;
        root = 0;
        for (int b = 20; b >= 0; b--)
            if ((root | (64'sd1 << b)) * (root | (64'sd1 << b)) <= val)
                root = root | (64'sd1 << b);
        return root;
    endfunction

    // Applies one accepted transfer to the predictor; returns 1 with a result for evaluate.
    function automatic bit predict_ospa(logic [1:0] kind, logic [15:0] x, logic [15:0] y,
                                        output ospa_t res);
        int     n, pairs;
        longint sum, c2;
        res = '0;
        if (kind == KIND_TRUTH || kind == KIND_EST) begin
            if (kind == KIND_TRUTH && n_truth < NPTS) truth_set[n_truth++] = {x, y};
            else if (kind == KIND_EST && n_est < NPTS) est_set[n_est++] = {x, y};
            else dropped = 1'b1;
            return 1'b0;
        end
        if (kind != KIND_EVAL) return 1'b0;
        n = n_truth > n_est ? n_truth : n_est;
        pairs = n_truth < n_est ? n_truth : n_est;
        c2 = longint'(cut_reg) * longint'(cut_reg);
        sum = 0;
        if (pairs > 0) begin
            for (int i = 0; i < n_truth; i++)
                for (int j = 0; j < n_est; j++)
                    cost_tab[i][j] = clipped_sq_dist(truth_set[i], est_set[j]);
            if (n_truth <= n_est) sum = min_assign_cost(n_truth, n_est, 1'b1);
            else sum = min_assign_cost(n_est, n_truth, 1'b0);
        end
        sum += longint'(n - pairs) * c2;
        res.distance = n == 0 ? 16'd0 : 16'(int_sqrt(sum / n));
        res.pairs = 5'(pairs);
        res.ovf = dropped;
        n_truth = 0;
        n_est = 0;
        dropped = 1'b0;
        return 1'b1;
    endfunction

    // Offers one item and waits for its transfer; the sender idles in bursts.
    task automatic send_item(logic [1:0] kind, logic [15:0] x, logic [15:0] y,
                             bit typed, ospa_t typed_res);
        ospa_t res;
        int    gap;
        i_valid <= 1'b1;
        i_kind <= kind;
        i_point_x <= x;
        i_point_y <= y;
        do @(posedge i_clk); while (!o_ready);
        if (predict_ospa(kind, x, y, res)) pending_ospa.push_back(typed ? typed_res : res);
        if (kind != KIND_UNUSED) sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_ospa.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cutoff(logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cut_reg = val;
    endtask

    function automatic logic [15:0] near_coord(logic [15:0] centre);
        int spread;
        spread = int'(cut_reg) / 2 + 2;
        return centre + 16'($urandom_range(0, 2 * spread) - spread);
    endfunction

    // One random scene: two point sets with random content, with the odd unused-kind item, then an evaluate.
    task automatic random_scene();
        int          nt, ne, sel;
        bit          spread_out;
        logic [15:0] cx, cy;
        ospa_t       none;
        none = '0;
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
            nt = $urandom_range(14, 18); ne = $urandom_range(14, 18);
        end else if (sel < 10) begin
            nt = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4);
            ne = nt == 0 ? $urandom_range(0, 4) : 0;
        end else begin
            nt = $urandom_range(0, 5); ne = $urandom_range(0, 5);
        end
        spread_out = $urandom_range(0, 3) == 0;
        cx = 16'($urandom); cy = 16'($urandom);
        while (nt + ne > 0) begin
            if ($urandom_range(0, 19) == 0)
                send_item(KIND_UNUSED, 16'($urandom), 16'($urandom), 1'b0, none);
            sel = $urandom_range(1, nt + ne);
            send_item(sel <= nt ? KIND_TRUTH : KIND_EST,
                      spread_out ? 16'($urandom) : near_coord(cx),
                      spread_out ? 16'($urandom) : near_coord(cy), 1'b0, none);
            if (sel <= nt) nt--;
            else ne--;
        end
        send_item(KIND_EVAL, 16'($urandom), 16'($urandom), 1'b0, none);
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        ospa_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_ospa.size() == 0) begin
                $display("%0t: unexpected result transfer, dist %0d pairs %0d ovf %0d",
                         $time, o_ospa_distance, o_matched_pairs, o_capacity_overflow);
                errors++;
            end else begin
                want = pending_ospa.pop_front();
                if (o_ospa_distance !== want.distance) begin
                    $display("%0t: distance expected %0d actual %0d",
                             $time, want.distance, o_ospa_distance);
                    errors++;
                end
                if (o_matched_pairs !== want.pairs) begin
                    $display("%0t: matched pairs expected %0d actual %0d",
                             $time, want.pairs, o_matched_pairs);
                    errors++;
                end
                if (o_capacity_overflow !== want.ovf) begin
                    $display("%0t: overflow flag expected %0d actual %0d",
                             $time, want.ovf, o_capacity_overflow);
                    errors++;
                end
            end
        end
    end

    // Receiver: stall rate changes every so often, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            i_ready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= 600) hold_done = 1'b1;
        end else begin
            pct_cnt++;
            if (pct_cnt >= 150) begin
                pct_cnt = 0;
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 70;
                    2: ready_pct = 35;
                    default: ready_pct = 10;
                endcase
            end
            i_ready <= $urandom_range(0, 99) < ready_pct;
        end
    end

    initial begin
        row_t        rows [$];
        row_t        r;
        logic [15:0] cutoffs [$];
        int          budget;
        rows.push_back('{KIND_EVAL, 16'h0, 16'h0, 1'b1, '{16'd0, 5'd0, 1'b0}});
        rows.push_back('{KIND_TRUTH, 16'h1234, 16'hFEDC, 1'b0, '0});
        rows.push_back('{KIND_EVAL, 16'hFFFF, 16'hFFFF, 1'b1, '{16'd65535, 5'd0, 1'b0}});
        rows.push_back('{KIND_TRUTH, 16'h8000, 16'h8000, 1'b0, '0});
        rows.push_back('{KIND_EST, 16'h7FFF, 16'h7FFF, 1'b0, '0});
        rows.push_back('{KIND_UNUSED, 16'h5555, 16'hAAAA, 1'b0, '0});
        rows.push_back('{KIND_EVAL, 16'h0, 16'h0, 1'b1, '{16'd65535, 5'd1, 1'b0}});
        rows.push_back('{KIND_EST, 16'h0010, 16'hFFF0, 1'b0, '0});
        rows.push_back('{KIND_TRUTH, 16'h0013, 16'hFFF4, 1'b0, '0});
        rows.push_back('{KIND_EVAL, 16'h0, 16'h0, 1'b1, '{16'd5, 5'd1, 1'b0}});
        for (int k = 0; k < 17; k++)
            rows.push_back('{KIND_EST, 16'(k * 1000), 16'(-k), 1'b0, '0});
        rows.push_back('{KIND_EVAL, 16'h0, 16'h0, 1'b1, '{16'd65535, 5'd0, 1'b1}});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            r = rows[k];
            send_item(r.kind, r.x, r.y, r.typed, r.res);
        end
        drain();

        cutoffs = '{16'd0, 16'd65535, 16'd1, 16'd300, 16'($urandom), 16'd5000, 16'd65535};
        budget = 1550 / cutoffs.size();
        foreach (cutoffs[p]) begin
            write_cutoff(cutoffs[p]);
            sent = 0;
            while (sent < budget) begin
                if (p == 1 && sent > budget / 3) hold_go = 1'b1;
                random_scene();
            end
            drain();
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/ospa_pkg.sv
hw/rtl/ospa_ram.sv
hw/rtl/ospa_distance_optimal_assignment.sv
verif/ospa_distance_optimal_assignment_tb.sv
